// ===== design/tlfs_pkg.sv =====
// shared types and codes of the three-level feedback scheduler
`timescale 1ns / 1ps

package tlfs_pkg;

   localparam int LEVELS = 3;

   typedef logic [3:0] task_id_type;
   typedef logic [1:0] level_type;
   typedef logic [1:0] action_type;
   typedef logic [1:0] status_type;

   localparam level_type LVL_TOP = 2'd0;
   localparam level_type LVL_MID = 2'd1;
   localparam level_type LVL_BOT = 2'd2;

   localparam action_type ACT_ADMIT  = 2'd0;
   localparam action_type ACT_SWITCH = 2'd1;
   localparam action_type ACT_BLOCK  = 2'd2;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_EMPTY = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

endpackage

// ===== design/tlfs_qram.sv =====
// ready queue storage: one write port, one read port with registered data
`timescale 1ns / 1ps

module tlfs_qram
   import tlfs_pkg::*;
#(
   parameter int DEPTH  = 48,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  task_id_type       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output task_id_type       rd_data
);

   task_id_type mem [DEPTH];
   task_id_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/three_level_feedback_scheduler.sv =====
// top level of the three-level feedback scheduler
`timescale 1ns / 1ps

// three-level feedback scheduler
// req channel: one item per scheduler event; req_tuser[1:0] is the action
//   (admit, preempt and switch, block and switch), req_tdata[3:0] the task id
//   used by admit (folded into 0..TASKS-1)
// rsp channel: one item per accepted req item with the running task, its
//   valid flag, its level and a status code (ok, no ready task, queue full)
// the three ready queues share one memory of 3*TASKS entries, at most one
//   write and one read per item; a task requeued into an empty queue and
//   picked right back is forwarded from the running task, not the read data
// each item passes accept and dispatch: the accept cycle does the queue write
//   and issues the head read, the dispatch state takes the read data and loads
//   the rsp register, so no new item is accepted until dispatch is left
// rsp_tvalid is registered: the accept moves the state to dispatch, and
//   rsp_tvalid is set when dispatch finds the rsp register free
// a stalled rsp side holds the pending item in the dispatch state and blocks
//   req until the waiting result is taken; one finished result may wait
//   while the next item is accepted
// reset empties all queues and leaves nothing running; no clearing pass is
//   needed, queue memory read data is used only where it was written
module three_level_feedback_scheduler
   import tlfs_pkg::*;
#(
   parameter int TASKS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] task_id, [7:4] zero
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [3:0] running_task, [4] running_valid,
                                    // [6:5] running_level, [8:7] status,
                                    // [15:9] zero
);

   localparam int PTR_W  = $clog2(TASKS);
   localparam int CNT_W  = $clog2(TASKS + 1);
   localparam int DEPTH  = LEVELS * TASKS;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [1:0] {
      S_IDLE     = 2'b01,
      S_DISPATCH = 2'b10
   } state_type;

   // fold a raw id into 0..TASKS-1 by repeated subtraction
   function automatic task_id_type id_fold(input task_id_type raw);
      logic [8:0] v;
      v = {5'b0, raw};
      for (int i = 0; i < 8; i++) begin
         if (v >= 9'(TASKS)) begin
            v = v - 9'(TASKS);
         end
      end
      return v[3:0];
   endfunction

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(TASKS - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [ADDR_W-1:0] qaddr(input level_type lvl,
                                               input logic [PTR_W-1:0] p);
      return ADDR_W'(lvl) * ADDR_W'(TASKS) + ADDR_W'(p);
   endfunction

   // control and queue bookkeeping
   state_type        state_ff, state_in;
   logic [PTR_W-1:0] heads_ff [LEVELS];
   logic [PTR_W-1:0] heads_in [LEVELS];
   logic [PTR_W-1:0] tails_ff [LEVELS];
   logic [PTR_W-1:0] tails_in [LEVELS];
   logic [CNT_W-1:0] cnt_ff   [LEVELS];
   logic [CNT_W-1:0] cnt_mid  [LEVELS];
   logic [CNT_W-1:0] cnt_in   [LEVELS];

   // running task
   task_id_type cur_task_ff;
   logic        cur_valid_ff;
   level_type   cur_level_ff;

   // item in flight between accept and result
   logic        pend_disp_ff;
   logic        pend_found_ff;
   logic        pend_fwd_ff;
   level_type   pend_lvl_ff;
   status_type  pend_status_ff;

   // result register
   logic        rsp_valid_ff;
   logic [15:0] rsp_data_ff;

   // accept path
   logic        req_fire;
   action_type  req_action;
   task_id_type req_id;
   logic        wr_en;
   level_type   wr_lvl;
   task_id_type wr_data;
   logic        disp_req;
   logic        disp_found;
   level_type   disp_lvl;
   logic        disp_fwd;
   logic        admit_hit;
   status_type  acc_status;
   level_type   demote_lvl;
   task_id_type rd_data;

   // result path
   logic        rsp_free;
   logic        done;
   task_id_type new_task;
   logic        new_valid;
   level_type   new_level;

   assign req_action = req_tuser;
   assign req_id     = id_fold(req_tdata[3:0]);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign demote_lvl = (cur_level_ff == LVL_BOT) ? LVL_BOT : cur_level_ff + 1'b1;

   always_comb begin
      heads_in   = heads_ff;
      tails_in   = tails_ff;
      cnt_mid    = cnt_ff;
      wr_en      = 1'b0;
      wr_lvl     = LVL_TOP;
      wr_data    = req_id;
      disp_req   = 1'b0;
      admit_hit  = 1'b0;
      acc_status = ST_OK;
      unique case (req_action)
         ACT_ADMIT: begin
            if (cnt_ff[LVL_TOP] == CNT_W'(TASKS)) begin
               acc_status = ST_FULL;
            end else begin
               wr_en     = 1'b1;
               admit_hit = cur_valid_ff && (cur_task_ff == req_id);
            end
         end
         ACT_SWITCH: begin
            if (!cur_valid_ff) begin
               disp_req = 1'b1;
            end else if (cnt_ff[demote_lvl] == CNT_W'(TASKS)) begin
               acc_status = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_lvl   = demote_lvl;
               wr_data  = cur_task_ff;
               disp_req = 1'b1;
            end
         end
         ACT_BLOCK: begin
            disp_req = 1'b1;
         end
         default: begin
         end
      endcase

      if (wr_en) begin
         tails_in[wr_lvl] = bump(tails_ff[wr_lvl]);
         cnt_mid[wr_lvl]  = cnt_ff[wr_lvl] + 1'b1;
      end
      cnt_in = cnt_mid;

      // highest non-empty queue after the requeue
      disp_found = 1'b0;
      disp_lvl   = LVL_TOP;
      if (disp_req) begin
         if (cnt_mid[LVL_TOP] != '0) begin
            disp_found = 1'b1;
            disp_lvl   = LVL_TOP;
         end else if (cnt_mid[LVL_MID] != '0) begin
            disp_found = 1'b1;
            disp_lvl   = LVL_MID;
         end else if (cnt_mid[LVL_BOT] != '0) begin
            disp_found = 1'b1;
            disp_lvl   = LVL_BOT;
         end
         if (acc_status == ST_OK && !disp_found) begin
            acc_status = ST_EMPTY;
         end
      end
      if (disp_found) begin
         heads_in[disp_lvl] = bump(heads_ff[disp_lvl]);
         cnt_in[disp_lvl]   = cnt_mid[disp_lvl] - 1'b1;
      end

      // head read hits the entry written this cycle
      disp_fwd = disp_found && wr_en && (wr_lvl == disp_lvl) &&
                 (cnt_ff[disp_lvl] == '0);
   end

   tlfs_qram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_qram (
      .clock   (clock),
      .wr_en   (req_fire && wr_en),
      .wr_addr (qaddr(wr_lvl, tails_ff[wr_lvl])),
      .wr_data (wr_data),
      .rd_en   (req_fire && disp_found),
      .rd_addr (qaddr(disp_lvl, heads_ff[disp_lvl])),
      .rd_data (rd_data)
   );

   // dispatch state: resolve the dispatch and load the result
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign done     = (state_ff == S_DISPATCH) && rsp_free;

   always_comb begin
      new_task  = cur_task_ff;
      new_valid = cur_valid_ff;
      new_level = cur_level_ff;
      if (pend_disp_ff) begin
         if (pend_found_ff) begin
            new_task  = pend_fwd_ff ? cur_task_ff : rd_data;
            new_valid = 1'b1;
            new_level = pend_lvl_ff;
         end else begin
            new_task  = '0;
            new_valid = 1'b0;
            new_level = LVL_TOP;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_task_ff  <= '0;
         cur_valid_ff <= 1'b0;
         cur_level_ff <= LVL_TOP;
         rsp_valid_ff <= 1'b0;
         pend_disp_ff <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            heads_ff[i] <= '0;
            tails_ff[i] <= '0;
            cnt_ff[i]   <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            heads_ff     <= heads_in;
            tails_ff     <= tails_in;
            cnt_ff       <= cnt_in;
            pend_disp_ff <= disp_req;
            if (admit_hit) begin
               cur_level_ff <= LVL_TOP;
            end
         end
         if (done) begin
            cur_task_ff  <= new_task;
            cur_valid_ff <= new_valid;
            cur_level_ff <= new_level;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload of the item in flight and of the result
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pend_found_ff  <= disp_found;
         pend_fwd_ff    <= disp_fwd;
         pend_lvl_ff    <= disp_lvl;
         pend_status_ff <= acc_status;
      end
      if (done) begin
         rsp_data_ff <= {7'b0, pend_status_ff, new_level, new_valid, new_task};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   // no queue ever holds more than its depth
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff[LVL_TOP] <= CNT_W'(TASKS) && cnt_ff[LVL_MID] <= CNT_W'(TASKS) &&
      cnt_ff[LVL_BOT] <= CNT_W'(TASKS))
      else $error("queue count beyond depth");

   // top queue pointers agree with its count
   assert property (@(posedge clock) disable iff (reset)
      ((cnt_ff[LVL_TOP] == '0) || (cnt_ff[LVL_TOP] == CNT_W'(TASKS))) ==
      (heads_ff[LVL_TOP] == tails_ff[LVL_TOP]))
      else $error("top queue pointers disagree with count");

   // nothing running reports task and level zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[4] |-> rsp_tdata[3:0] == '0 && rsp_tdata[6:5] == '0)
      else $error("idle result carries a task");

   // an accepted item blocks req while it is in flight
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while one is in flight");

   // a forwarded dispatch always comes with a found task
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DISPATCH && pend_fwd_ff |-> pend_found_ff && pend_disp_ff)
      else $error("forward without dispatch");
`endif

endmodule
